// ----- hw/rtl/ird_pkg.sv -----
// Shared types, constants and helpers for the radix digit converter.
// Depends on nothing; every other RTL file imports it.
package ird_pkg;

  localparam int VALUE_BITS = 32;
  localparam int DIG_W      = 4;
  localparam int RADIX_W    = 5;
  localparam int CNT_W      = $clog2(VALUE_BITS) + 1;
  localparam int BIT_W      = $clog2(VALUE_BITS);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  // Register index, taken from the word address.
  localparam logic [PADDR_W-3:0] REG_RADIX = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } ird_state_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [DIG_W-1:0] din;
  } ird_stack_cmd_t;

  // Bases below two act as two, bases above sixteen act as sixteen.
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/ird_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ird_pkg for widths.
module ird_div
  import ird_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIG_W-1:0]      remainder
);

  logic                  running;
  logic [BIT_W-1:0]      bit_cnt;
  logic [VALUE_BITS-1:0] quo;
  logic [DIG_W-1:0]      rem;
  logic [DIG_W:0]        trial;
  logic [DIG_W:0]        diff;
  logic                  take;

  // The remainder stays below the divisor, so it fits in one digit.
  assign trial = {rem, quo[VALUE_BITS-1]};
  assign take  = (trial >= divisor);
  assign diff  = trial - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        bit_cnt <= '0;
      end else if (running) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == BIT_W'(VALUE_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (running) begin
      quo <= {quo[VALUE_BITS-2:0], take};
      rem <= take ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- hw/rtl/ird_stack.sv -----
// Digit stack built as a shift register; the top of stack is entry 0.
// Depends on ird_pkg for the command struct and depth.
module ird_stack
  import ird_pkg::*;
(
  input  logic             clk,
  input  ird_stack_cmd_t   cmd,
  output logic [DIG_W-1:0] top
);

  logic [DIG_W-1:0] entry [VALUE_BITS];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      entry[0] <= cmd.din;
      for (int i = 1; i < VALUE_BITS; i++) begin
        entry[i] <= entry[i-1];
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        entry[i] <= entry[i+1];
      end
    end
  end

  assign top = entry[0];

endmodule

// ----- hw/rtl/integer_to_radix_digits_unit.sv -----
// Radix conversion by repeated division, digits emitted most significant first.
// Each digit but the last takes a check, a 32-step division and a push onto the stack;
// the final quotient is pushed as it stands, then the digits are popped and strobed
// on consecutive cycles. A new number is accepted only while idle, once the last
// digit of the previous one has been emitted. rst is synchronous, clears control state
// and sets radix to 10. The receiver cannot stall; results are strobed once.
module integer_to_radix_digits_unit
  import ird_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  result_valid,
  output logic [DIG_W-1:0]      digit,
  output logic                  last_digit,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  ird_state_t            state, state_next;
  logic [RADIX_W-1:0]    radix;
  logic [RADIX_W-1:0]    base;
  logic [VALUE_BITS-1:0] quot, quot_next;
  logic [CNT_W-1:0]      count, count_next;
  logic                  emit_valid, emit_last;
  logic                  div_start, div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [DIG_W-1:0]      div_rem;
  logic [DIG_W-1:0]      stack_top;
  ird_stack_cmd_t        stack_cmd;
  logic                  more;

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_RADIX) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end
  assign prdata = (paddr[PADDR_W-1:2] == REG_RADIX) ?
                  {{(PDATA_W-RADIX_W){1'b0}}, radix} : '0;

  assign base = eff_radix(radix);
  assign busy = (state != ST_IDLE);

  // Another division is due while the quotient is not below the base and fewer than 31 digits are stacked.
  assign more = ((quot[VALUE_BITS-1:RADIX_W] != '0) || (quot[RADIX_W-1:0] >= base)) &&
                (count < CNT_W'(VALUE_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    quot <= quot_next;
    if (emit_valid) begin
      digit      <= stack_top;
      last_digit <= emit_last;
    end
  end

  always_comb begin
    state_next    = state;
    quot_next     = quot;
    count_next    = count;
    div_start     = 1'b0;
    emit_valid    = 1'b0;
    emit_last     = 1'b0;
    stack_cmd     = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          quot_next  = value;
          count_next = '0;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (more) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          stack_cmd.push = 1'b1;
          stack_cmd.din  = quot[DIG_W-1:0];
          count_next     = count + 1'b1;
          state_next     = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          stack_cmd.push = 1'b1;
          stack_cmd.din  = div_rem;
          quot_next      = div_quo;
          count_next     = count + 1'b1;
          state_next     = ST_CHECK;
        end
      end
      ST_EMIT: begin
        emit_valid    = 1'b1;
        emit_last     = (count == CNT_W'(1));
        stack_cmd.pop = 1'b1;
        count_next    = count - 1'b1;
        if (emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  ird_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (quot),
    .divisor   (base),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ird_stack u_stack (
    .clk (clk),
    .cmd (stack_cmd),
    .top (stack_top)
  );

  // The final digit of a transaction is never followed by a strobe in the next cycle.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_digit |=> !result_valid)
    else $error("strobe right after last digit");

  // Every strobe comes from a cycle spent emitting.
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_EMIT))
    else $error("strobe without emission");

  // The digit count never exceeds the stack depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(VALUE_BITS))
    else $error("digit count overflow");

  // A divider result only arrives while waiting for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider done outside division");

endmodule

// ----- test/ird_checker.sv -----
// Scoreboard for the radix digit converter: watches the command, result and APB channels,
// predicts the digit stream of every accepted number and compares it with the block's output.
// Depends on ird_pkg for widths and the register index.
module ird_checker
  import ird_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  result_valid,
  input  logic [DIG_W-1:0]      digit,
  input  logic                  last_digit,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  input  logic [PDATA_W-1:0]    prdata,
  input  logic                  pready,
  output int                    errors,
  output int                    pending,
  output int                    digits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic             last;
  } digit_rec_t;

  digit_rec_t       expected_digits[$];
  logic [RADIX_W-1:0] radix_copy;
  int               err_count;
  int               digit_count;

  initial begin
    err_count   = 0;
    digit_count = 0;
    radix_copy  = RADIX_RESET;
  end

  always @(posedge clk) begin : watch
    logic [DIG_W-1:0] lsd_first[VALUE_BITS];
    int unsigned      base;
    int unsigned      quot;
    int               n;
    digit_rec_t       want;
    logic [PDATA_W-1:0] rd_want;

    if (rst) begin
      radix_copy = RADIX_RESET;
      expected_digits.delete();
    end else begin
      // Results are checked before the new number is expanded, so the order holds.
      if (result_valid) begin
        digit_count++;
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected digit transaction: expected none, actual digit %0d last %0b",
                   $time, digit, last_digit);
          err_count++;
        end else begin
          want = expected_digits.pop_front();
          if (digit !== want.digit) begin
            $display("%0t: digit mismatch: expected %0d, actual %0d", $time, want.digit, digit);
            err_count++;
          end
          if (last_digit !== want.last) begin
            $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                     $time, want.last, last_digit);
            err_count++;
          end
        end
      end

      if (start && !busy) begin
        if (radix_copy < 2) begin
          base = 2;
        end else if (radix_copy > 16) begin
          base = 16;
        end else begin
          base = 32'(radix_copy);
        end
        quot = value;
        n = 0;
        while (quot >= base && n < VALUE_BITS - 1) begin
          lsd_first[n] = DIG_W'(quot % base);
          quot = quot / base;
          n++;
        end
        lsd_first[n] = DIG_W'(quot);
        n++;
        for (int k = n - 1; k >= 0; k--) begin
          want.digit = lsd_first[k];
          want.last  = (k == 0);
          expected_digits.push_back(want);
        end
      end

      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_RADIX) begin
        if (pwrite) begin
          radix_copy = pwdata[RADIX_W-1:0];
        end else begin
          rd_want = PDATA_W'(radix_copy);
          if (prdata !== rd_want) begin
            $display("%0t: radix readback mismatch: expected %0d, actual %0d",
                     $time, rd_want, prdata);
            err_count++;
          end
        end
      end
    end

    errors      <= err_count;
    pending     <= expected_digits.size();
    digits_seen <= digit_count;
  end

endmodule

// ----- test/integer_to_radix_digits_unit_tb.sv -----
// Top of the radix digit converter testbench: clock, reset, bursty number stimulus and APB
// radix changes between phases. Depends on ird_pkg, the block and the ird_checker scoreboard.
module integer_to_radix_digits_unit_tb;
  import ird_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 6000;
  localparam int RANDOM_ITEMS = 160;
  localparam logic [PADDR_W-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  result_valid;
  logic [DIG_W-1:0]      digit;
  logic                  last_digit;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  int errors;
  int pending;
  int digits_seen;
  int burst_left = 0;
  int numbers_sent = 0;
  int radix_settings = 1;
  int idle_cycles = 0;

  integer_to_radix_digits_unit DUT (
    .clk, .rst, .start, .busy, .value, .result_valid, .digit, .last_digit,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ird_checker scoreboard (
    .clk, .rst, .start, .busy, .value, .result_valid, .digit, .last_digit,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .errors, .pending, .digits_seen
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Counts cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired with %0d digits outstanding", $time, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_number(input logic [VALUE_BITS-1:0] v);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 20);
        default: gap = $urandom_range(1, 1200);
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    burst_left--;
    numbers_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are random; only the low five reach the register.
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    wait_drained();
    apb_access(1'b1, RADIX_ADDR, {$urandom()} & ~PDATA_W'({RADIX_W{1'b1}}) | PDATA_W'(r));
    apb_access(1'b0, RADIX_ADDR, $urandom());
    radix_settings++;
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_number(input logic [RADIX_W-1:0] r);
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom();
      4, 5:       v = $urandom_range(0, (int'(r) + 1) * (int'(r) + 1));
      6:          v = (VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1)) - $urandom_range(0, 1);
      7:          v = $urandom_range(0, 1) ? '1 : '0;
      default:    v = $urandom() >> $urandom_range(0, VALUE_BITS - 1);
    endcase
    return v;
  endfunction

  initial begin
    logic [RADIX_W-1:0] extremes[6];
    logic [RADIX_W-1:0] r;
    int count;

    extremes = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd3, 5'd15};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, starting at the reset base of ten.
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd9);
    send_number(32'd10);
    send_number(32'd100);
    send_number(32'hFFFF_FFFF);
    send_number(32'h8000_0000);
    apb_access(1'b0, RADIX_ADDR, '0);
    set_radix(5'd2);
    send_number(32'd0);
    send_number(32'd2);
    send_number(32'hFFFF_FFFF);
    send_number(32'h8000_0000);
    set_radix(5'd16);
    send_number(32'hF);
    send_number(32'h10);
    send_number(32'hFEDC_BA98);
    set_radix(5'd0);
    send_number(32'd5);
    set_radix(5'd1);
    send_number(32'd3);
    set_radix(5'd31);
    send_number(32'hABCD);
    set_radix(5'd17);
    send_number(32'd255);
    set_radix(5'd3);
    send_number(32'hFFFF_FFFF);

    // A write to an unmapped word must leave the base alone.
    wait_drained();
    apb_access(1'b1, 3'd4, $urandom());
    send_number(32'd12345);

    count = 0;
    for (int phase = 0; count < RANDOM_ITEMS; phase++) begin
      r = (phase < 6) ? extremes[phase] : 5'($urandom_range(0, 31));
      set_radix(r);
      for (int i = $urandom_range(10, 22); i > 0 && count < RANDOM_ITEMS; i--) begin
        send_number(pick_number(r));
        count++;
      end
    end

    set_radix(RADIX_RESET);
    send_number($urandom());
    wait_drained();
    repeat (64) @(posedge clk);

    $display("Converted %0d numbers into %0d digits across %0d base settings.",
             numbers_sent, digits_seen, radix_settings);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- integer_to_radix_digits_unit.f -----
hw/rtl/ird_pkg.sv
hw/rtl/ird_div.sv
hw/rtl/ird_stack.sv
hw/rtl/integer_to_radix_digits_unit.sv
test/ird_checker.sv
test/integer_to_radix_digits_unit_tb.sv
